// ===== sv/sct_pkg.sv =====
`timescale 1ns / 1ps

package sct_pkg;

  localparam int unsigned HIGHEST_POWER = 10;

  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned VALUE_W  = 19;
  localparam int unsigned DATA_O_W = 24;

  localparam int unsigned A_W      = 17;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned X_W      = 27;
  localparam int unsigned X2_W     = 30;
  localparam int unsigned TERM_W   = 31;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned N_W      = 36;
  localparam int unsigned HALF_N   = 18;
  localparam int unsigned RECIP_W  = 36;
  localparam int unsigned Q_FRAC   = 24;
  localparam int unsigned OUT_SHIFT = 8;

  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic signed [A_W-1:0] QUARTER_TURN_Q7 = 17'sd11520;
  localparam logic [TERM_W-1:0] ONE_Q24 = 31'd16777216;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 19'sd262143;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -19'sd262144;

  typedef struct packed {
    logic [X2_W-1:0]          x2;
    logic [TERM_W-1:0]        term;
    logic signed [SUM_W-1:0]  sum;
  } cell_word_t;

endpackage

// ===== sv/sct_front.sv =====
`timescale 1ns / 1ps

module sct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic signed [sct_pkg::ANGLE_W-1:0] angle_deg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sct_pkg::cell_word_t           out_word_o
);

  localparam int unsigned Stages = 3;
  localparam int unsigned XpW = sct_pkg::MAG_W + 27;
  localparam int unsigned SqW = 2 * sct_pkg::X_W;

  logic [Stages-1:0] v_q, v_d, rdy;

  logic signed [sct_pkg::A_W-1:0] a;
  logic [sct_pkg::A_W-1:0]        a_abs;
  logic [sct_pkg::MAG_W-1:0]      mag_q, mag_d;
  logic [XpW-1:0]                 xp;
  logic [sct_pkg::X_W-1:0]        x_q, x_d;
  logic [SqW-1:0]                 sq;
  logic [sct_pkg::X2_W-1:0]       x2_q, x2_d;

  always_comb begin
    rdy[Stages-1] = !v_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < Stages; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_comb begin
    a = sct_pkg::A_W'(angle_deg_i)
        + (req_type_i ? sct_pkg::QUARTER_TURN_Q7 : '0);
    a_abs = a[sct_pkg::A_W-1] ? sct_pkg::A_W'(-a) : sct_pkg::A_W'(a);
    mag_d = a_abs[sct_pkg::MAG_W-1:0];

    xp  = XpW'(mag_q) * XpW'(sct_pkg::DEG2RAD_Q32) + XpW'(1 << 14);
    x_d = xp[sct_pkg::X_W+15-1:15];

    sq   = SqW'(x_q) * SqW'(x_q) + SqW'(1 << 23);
    x2_d = sq[sct_pkg::X2_W+sct_pkg::Q_FRAC-1:sct_pkg::Q_FRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mag_q <= mag_d;
    end
    if (rdy[1]) begin
      x_q <= x_d;
    end
    if (rdy[2]) begin
      x2_q <= x2_d;
    end
  end

  assign in_ready_o       = rdy[0];
  assign out_valid_o      = v_q[Stages-1];
  assign out_word_o.x2    = x2_q;
  assign out_word_o.term  = sct_pkg::ONE_Q24;
  assign out_word_o.sum   = $signed(sct_pkg::SUM_W'(sct_pkg::ONE_Q24));

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted word did not enter the first stage");

endmodule

// ===== sv/sct_cell.sv =====
`timescale 1ns / 1ps

module sct_cell #(
  parameter int unsigned POWER = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sct_pkg::cell_word_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sct_pkg::cell_word_t out_word_o
);

  localparam int unsigned Stages  = 4;
  localparam int unsigned Div     = POWER * (POWER - 1);
  localparam int unsigned HalfDiv = Div / 2;
  localparam bit          Subtract = ((POWER / 2) % 2) == 1;
  localparam int unsigned NW   = sct_pkg::N_W;
  localparam int unsigned HN   = sct_pkg::HALF_N;
  localparam int unsigned RW   = sct_pkg::RECIP_W;
  localparam int unsigned TW   = sct_pkg::TERM_W;
  localparam int unsigned PW   = sct_pkg::TERM_W + sct_pkg::X2_W;
  localparam int unsigned PPW  = HN + RW;
  localparam int unsigned FW   = PPW + HN;
  localparam logic [FW:0] One  = 1;
  localparam logic [RW-1:0] Recip = RW'((One << NW) / Div);

  logic [Stages-1:0] v_q, v_d, rdy;

  logic [PW-1:0]               prod;
  logic [NW-1:0]               p_q, p_d;
  logic [NW-1:0]               n;
  logic [NW-1:0]               n2_q, n3_q;
  logic [PPW-1:0]              ph_q, ph_d, pl_q, pl_d;
  logic [FW-1:0]               full;
  logic [TW-1:0]               qe_q, qe_d;
  logic [NW-1:0]               qd, rem;
  logic [TW-1:0]               term_q, term_d;
  logic signed [sct_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [sct_pkg::X2_W-1:0]    x2_1_q, x2_2_q, x2_3_q, x2_4_q;
  logic signed [sct_pkg::SUM_W-1:0] s1_q, s2_q, s3_q;

  always_comb begin
    rdy[Stages-1] = !v_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < Stages; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_comb begin
    prod = PW'(in_word_i.term) * PW'(in_word_i.x2) + PW'(1 << 23);
    p_d  = prod[NW+sct_pkg::Q_FRAC-1:sct_pkg::Q_FRAC];

    n    = p_q + NW'(HalfDiv);
    ph_d = PPW'(n[NW-1:HN]) * PPW'(Recip);
    pl_d = PPW'(n[HN-1:0]) * PPW'(Recip);

    full = {ph_q, {HN{1'b0}}} + FW'(pl_q);
    qe_d = full[TW+NW-1:NW];

    qd     = NW'(qe_q) * NW'(Div);
    rem    = n3_q - qd;
    term_d = (rem >= NW'(Div)) ? qe_q + TW'(1) : qe_q;
    if (Subtract) begin
      sum_d = s3_q - $signed(sct_pkg::SUM_W'(term_d));
    end else begin
      sum_d = s3_q + $signed(sct_pkg::SUM_W'(term_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_q    <= p_d;
      x2_1_q <= in_word_i.x2;
      s1_q   <= in_word_i.sum;
    end
    if (rdy[1]) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      n2_q   <= n;
      x2_2_q <= x2_1_q;
      s2_q   <= s1_q;
    end
    if (rdy[2]) begin
      qe_q   <= qe_d;
      n3_q   <= n2_q;
      x2_3_q <= x2_2_q;
      s3_q   <= s2_q;
    end
    if (rdy[3]) begin
      term_q <= term_d;
      sum_q  <= sum_d;
      x2_4_q <= x2_3_q;
    end
  end

  assign in_ready_o      = rdy[0];
  assign out_valid_o     = v_q[Stages-1];
  assign out_word_o.x2   = x2_4_q;
  assign out_word_o.term = term_q;
  assign out_word_o.sum  = sum_q;

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled cell output changed");

endmodule

// ===== sv/sct_back.sv =====
`timescale 1ns / 1ps

module sct_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sct_pkg::cell_word_t                in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sct_pkg::VALUE_W-1:0] trig_value_o,
  output logic                               saturated_o
);

  localparam int unsigned SW = sct_pkg::SUM_W;
  localparam int unsigned QW = SW - sct_pkg::OUT_SHIFT;

  logic                              v_q, v_d, rdy;
  logic signed [SW-1:0]              biased;
  logic signed [QW-1:0]              q16;
  logic signed [sct_pkg::VALUE_W-1:0] value_q, value_d;
  logic                              sat_q, sat_d;

  always_comb begin
    rdy = !v_q || out_ready_i;
    v_d = rdy ? in_valid_i : v_q;
  end

  always_comb begin
    biased = in_word_i.sum + SW'(1 << (sct_pkg::OUT_SHIFT - 1));
    q16    = QW'(biased >>> sct_pkg::OUT_SHIFT);
    if (q16 > QW'(sct_pkg::VALUE_MAX)) begin
      value_d = sct_pkg::VALUE_MAX;
      sat_d   = 1'b1;
    end else if (q16 < QW'(sct_pkg::VALUE_MIN)) begin
      value_d = sct_pkg::VALUE_MIN;
      sat_d   = 1'b1;
    end else begin
      value_d = q16[sct_pkg::VALUE_W-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign in_ready_o   = rdy;
  assign out_valid_o  = v_q;
  assign trig_value_o = value_q;
  assign saturated_o  = sat_q;

  a_sat_at_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      trig_value_o == sct_pkg::VALUE_MAX || trig_value_o == sct_pkg::VALUE_MIN)
    else $error("saturated flag set on an unclamped value");

  a_empty_after_reset : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

// ===== sv/sine_cosine_taylor_degrees_top.sv =====
`timescale 1ns / 1ps

// cosine or sine of a Q9.7 degree angle by the even Taylor series through the
// x^HIGHEST_POWER term, result signed Q3.16 with a saturation flag; no range
// reduction is done, so keep angles within plus or minus 180 degrees for good
// accuracy. one word is accepted every cycle while the output is not stalled;
// the pipeline is three front stages for degree to radian scaling and
// squaring, then one four-stage cell per series term (multiply by x^2,
// reciprocal multiply in two partial products, their sum to a quotient
// estimate, remainder correction and accumulate), then the rounding and
// clamp output register. a stalled output holds the word while bubbles
// upstream keep filling.
module sine_cosine_taylor_degrees_top #(
  parameter int unsigned HIGHEST_POWER = sct_pkg::HIGHEST_POWER
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // angle_deg
  input  logic        s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // trig_value, zero pad
  output logic        m_axis_tuser_o    // saturated
);

  localparam int unsigned NumCells = HIGHEST_POWER / 2;

  sct_pkg::cell_word_t       word  [NumCells+1];
  logic [NumCells:0]         valid;
  logic [NumCells:0]         ready;
  logic signed [sct_pkg::VALUE_W-1:0] trig_value;

  sct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .angle_deg_i ($signed(s_axis_tdata_i[sct_pkg::ANGLE_W-1:0])),
    .out_valid_o (valid[0]),
    .out_ready_i (ready[0]),
    .out_word_o  (word[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    sct_cell #(
      .POWER (2 * (k + 1))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_word_i   (word[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_word_o  (word[k+1])
    );
  end

  sct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid[NumCells]),
    .in_ready_o   (ready[NumCells]),
    .in_word_i    (word[NumCells]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .trig_value_o (trig_value),
    .saturated_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(sct_pkg::DATA_O_W - sct_pkg::VALUE_W){1'b0}}, trig_value};

endmodule
